/* sv/onset_peak_picker_defines.svh */
// assertion macros used by the port-level checker of the onset peak picker
`ifndef ONSET_PEAK_PICKER_DEFINES_SVH
`define ONSET_PEAK_PICKER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define OPP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define OPP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/opp_pkg.sv */
// types, constants and register codes of the onset peak picker
package opp_pkg;

	localparam int DETECT_W = 16;
	localparam int ENERGY_W = 16;
	localparam int POS_W = 16;
	localparam int WEIGHT_W = 16;
	localparam int THRESH_W = 15;
	localparam int DIST_W = 16;

	localparam int MAX_SAMPLES = 65536;
	localparam int COUNT_W = $clog2(MAX_SAMPLES + 1);
	// width for the position before saturation
	localparam int PCALC_W = (COUNT_W > POS_W) ? COUNT_W : POS_W + 1;
	localparam logic [POS_W-1:0] POS_MAX = '1;

	// position i is judged once sample i+3 has arrived
	localparam int JUDGE_LAG = 3;
	localparam int FIRST_JUDGE_COUNT = JUDGE_LAG + 1;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_INDEX_W-1:0] REG_PEAK_THRESHOLD = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_PEAK_DISTANCE = 2'd1;
	localparam logic [DIST_W-1:0] RESET_MIN_PEAK_DISTANCE = 16'd5;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [POS_W-1:0]    onset_position;
		logic [WEIGHT_W-1:0] onset_weight;
		logic                no_onset;
		logic                list_end;
	} opp_result_t;

	typedef struct packed {
		logic [THRESH_W-1:0] peak_threshold;
		logic [DIST_W-1:0]   min_peak_distance;
	} opp_cfg_t;

	// results produced by one input transaction, first goes out first
	typedef struct packed {
		logic [1:0]  count;
		opp_result_t first;
		opp_result_t second;
	} opp_push_t;

endpackage

/* sv/opp_if.sv */
// channel interfaces: sample input, onset output, configuration writes
interface opp_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [opp_pkg::DETECT_W-1:0]  detect_value;
	logic        [opp_pkg::ENERGY_W-1:0]  energy_value;
	logic                                 stream_end;

	modport source(output valid, detect_value, energy_value, stream_end, input ready);
	modport sink(input valid, detect_value, energy_value, stream_end, output ready);
	modport monitor(input valid, ready, detect_value, energy_value, stream_end);
endinterface

interface opp_out_if;
	logic                            valid;
	logic                            ready;
	logic [opp_pkg::POS_W-1:0]       onset_position;
	logic [opp_pkg::WEIGHT_W-1:0]    onset_weight;
	logic                            no_onset;
	logic                            list_end;

	modport source(output valid, onset_position, onset_weight, no_onset, list_end,
		input ready);
	modport sink(input valid, onset_position, onset_weight, no_onset, list_end,
		output ready);
	modport monitor(input valid, ready, onset_position, onset_weight, no_onset, list_end);
endinterface

interface opp_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [opp_pkg::CFG_INDEX_W-1:0]   index;
	logic [opp_pkg::CFG_DATA_W-1:0]    data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

/* sv/opp_core.sv */
// sample windows, region tracking and candidate clustering
module opp_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                fire,
	input  logic signed [opp_pkg::DETECT_W-1:0] detect_value,
	input  logic        [opp_pkg::ENERGY_W-1:0] energy_value,
	input  logic                                stream_end,
	input  opp_pkg::opp_cfg_t                   cfg,
	output opp_pkg::opp_push_t                  push
);

	logic signed [opp_pkg::DETECT_W-1:0] dw_q [3];
	logic        [opp_pkg::ENERGY_W-1:0] ew_q [4];
	logic [opp_pkg::COUNT_W-1:0]         count_q;
	logic                                in_region_q;
	logic [opp_pkg::THRESH_W-1:0]        rmax_det_q;
	logic [opp_pkg::POS_W-1:0]           rmax_pos_q;
	logic [opp_pkg::WEIGHT_W-1:0]        rmax_rise_q;
	logic                                pend_valid_q;
	logic [opp_pkg::POS_W-1:0]           pend_pos_q;
	logic [opp_pkg::WEIGHT_W-1:0]        pend_w_q;
	logic [opp_pkg::POS_W-1:0]           clast_q;

	logic                                active;
	logic                                judge;
	logic                                cond;
	logic [opp_pkg::PCALC_W-1:0]         p_wide;
	logic [opp_pkg::POS_W-1:0]           pos_sat;
	logic [opp_pkg::ENERGY_W:0]          rise_wide;
	logic                                rg_in;
	logic [opp_pkg::THRESH_W-1:0]        rg_det;
	logic [opp_pkg::POS_W-1:0]           rg_pos;
	logic [opp_pkg::WEIGHT_W-1:0]        rg_rise;
	logic                                close_rg;
	logic                                cand;
	logic [opp_pkg::POS_W:0]             gap_wide;
	logic                                merge;
	logic                                emit_closed;
	logic                                pv_n;
	logic [opp_pkg::POS_W-1:0]           pp_n;
	logic [opp_pkg::WEIGHT_W-1:0]        pw_n;
	logic [opp_pkg::POS_W-1:0]           cl_n;
	opp_pkg::opp_result_t                closed_res;
	opp_pkg::opp_result_t                final_res;

	always_comb begin
		active = count_q < opp_pkg::COUNT_W'(opp_pkg::MAX_SAMPLES);
		judge = active && (count_q >= opp_pkg::COUNT_W'(opp_pkg::FIRST_JUDGE_COUNT));
		cond = 1'b0;
		for (int k = 0; k < 3; k++) begin
			cond = cond || (!dw_q[k][opp_pkg::DETECT_W-1] && (dw_q[k] != '0));
		end
		p_wide = opp_pkg::PCALC_W'(count_q) - opp_pkg::PCALC_W'(opp_pkg::JUDGE_LAG);
		pos_sat = (p_wide > opp_pkg::PCALC_W'(opp_pkg::POS_MAX)) ? opp_pkg::POS_MAX
			: p_wide[opp_pkg::POS_W-1:0];
		// e[i+1] - e[i-1], sign in the top bit
		rise_wide = {1'b0, ew_q[2]} - {1'b0, ew_q[0]};

		rg_in = in_region_q;
		rg_det = rmax_det_q;
		rg_pos = rmax_pos_q;
		rg_rise = rmax_rise_q;
		if (judge && cond) begin
			if (!in_region_q) begin
				rg_det = '0;
				rg_pos = '0;
				rg_rise = '0;
			end
			rg_in = 1'b1;
			if (!dw_q[0][opp_pkg::DETECT_W-1] &&
				(dw_q[0][opp_pkg::THRESH_W-1:0] > rg_det)) begin
				rg_det = dw_q[0][opp_pkg::THRESH_W-1:0];
				rg_pos = pos_sat;
			end
			if (!rise_wide[opp_pkg::ENERGY_W] &&
				(rise_wide[opp_pkg::WEIGHT_W-1:0] > rg_rise)) begin
				rg_rise = rise_wide[opp_pkg::WEIGHT_W-1:0];
			end
		end

		// a region closes on a quiet judged position or at the end of the stream
		close_rg = (judge && !cond && in_region_q) || (stream_end && rg_in);
		cand = close_rg && (rg_det > cfg.peak_threshold);

		gap_wide = {1'b0, rg_pos} - {1'b0, clast_q};
		merge = pend_valid_q && !gap_wide[opp_pkg::POS_W] &&
			(gap_wide[opp_pkg::POS_W-1:0] < cfg.min_peak_distance);

		emit_closed = 1'b0;
		pv_n = pend_valid_q;
		pp_n = pend_pos_q;
		pw_n = pend_w_q;
		cl_n = clast_q;
		if (cand) begin
			cl_n = rg_pos;
			if (merge) begin
				if (rg_rise > pend_w_q) begin
					pp_n = rg_pos;
					pw_n = rg_rise;
				end
			end else begin
				emit_closed = pend_valid_q;
				pv_n = 1'b1;
				pp_n = rg_pos;
				pw_n = rg_rise;
			end
		end

		closed_res.onset_position = pend_pos_q;
		closed_res.onset_weight = pend_w_q;
		closed_res.no_onset = 1'b0;
		closed_res.list_end = 1'b0;

		final_res.onset_position = pv_n ? pp_n : '0;
		final_res.onset_weight = pv_n ? pw_n : '0;
		final_res.no_onset = !pv_n;
		final_res.list_end = 1'b1;

		push.first = emit_closed ? closed_res : final_res;
		push.second = final_res;
		push.count = fire ? ({1'b0, emit_closed} + {1'b0, stream_end}) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) dw_q[k] <= '0;
			for (int k = 0; k < 4; k++) ew_q[k] <= '0;
			count_q <= '0;
			in_region_q <= 1'b0;
			rmax_det_q <= '0;
			rmax_pos_q <= '0;
			rmax_rise_q <= '0;
			pend_valid_q <= 1'b0;
			pend_pos_q <= '0;
			pend_w_q <= '0;
			clast_q <= '0;
		end else if (fire) begin
			if (stream_end) begin
				for (int k = 0; k < 3; k++) dw_q[k] <= '0;
				for (int k = 0; k < 4; k++) ew_q[k] <= '0;
				count_q <= '0;
				in_region_q <= 1'b0;
				rmax_det_q <= '0;
				rmax_pos_q <= '0;
				rmax_rise_q <= '0;
				pend_valid_q <= 1'b0;
				pend_pos_q <= '0;
				pend_w_q <= '0;
				clast_q <= '0;
			end else begin
				if (active) begin
					dw_q[0] <= dw_q[1];
					dw_q[1] <= dw_q[2];
					dw_q[2] <= detect_value;
					ew_q[0] <= ew_q[1];
					ew_q[1] <= ew_q[2];
					ew_q[2] <= ew_q[3];
					ew_q[3] <= energy_value;
					count_q <= count_q + 1'b1;
				end
				in_region_q <= rg_in && !close_rg;
				rmax_det_q <= rg_det;
				rmax_pos_q <= rg_pos;
				rmax_rise_q <= rg_rise;
				pend_valid_q <= pv_n;
				pend_pos_q <= pp_n;
				pend_w_q <= pw_n;
				clast_q <= cl_n;
			end
		end
	end

endmodule

/* sv/opp_out_queue.sv */
// result queue taking up to two results per cycle and giving one
module opp_out_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  opp_pkg::opp_push_t   push,
	input  logic                 pop,
	output opp_pkg::opp_result_t head,
	output logic                 not_empty,
	output logic                 room
);

	opp_pkg::opp_result_t              mem_q [opp_pkg::QUEUE_DEPTH];
	logic [opp_pkg::QUEUE_PTR_W-1:0]   wr_ptr_q;
	logic [opp_pkg::QUEUE_PTR_W-1:0]   rd_ptr_q;
	logic [opp_pkg::QUEUE_CNT_W-1:0]   count_q;
	logic                              do_pop;

	assign not_empty = count_q != '0;
	// space for the two results one transaction can produce
	assign room = count_q <= opp_pkg::QUEUE_CNT_W'(opp_pkg::QUEUE_DEPTH - 2);
	assign head = mem_q[rd_ptr_q];
	assign do_pop = pop && not_empty;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_q + 1'b1] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + opp_pkg::QUEUE_PTR_W'(push.count);
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + opp_pkg::QUEUE_CNT_W'(push.count)
				- opp_pkg::QUEUE_CNT_W'(do_pop);
		end
	end

endmodule

/* sv/onset_peak_picker.sv */
// top level of the onset peak picker: config registers, core and result queue
//
//  channel   role    moves                                          per transaction
//  samples   sink    detect_value, energy_value, stream_end         one sample
//  onsets    source  onset_position, onset_weight, no_onset, list_end one result
//  cfg       sink    index, data                                    one register write
//
// one sample is taken per cycle while the queue has room; its results enter the queue
// at the same edge and show on onsets from the next cycle, up to two results per sample.
// samples.ready is low while the four-entry result queue has fewer than two free
// entries, so a stalled onsets channel stops the input once three results are queued.
// reset clears the stream state, sets peak_threshold to 0, min_peak_distance to 5.
// cfg.ready is always high.
module onset_peak_picker (
	input  logic      clk,
	input  logic      arst_n,
	opp_in_if.sink    samples,
	opp_out_if.source onsets,
	opp_cfg_if.sink   cfg
);

	opp_pkg::opp_cfg_t     cfg_q;
	opp_pkg::opp_push_t    push;
	opp_pkg::opp_result_t  head;
	logic                  in_fire;
	logic                  room;

	assign cfg.ready = 1'b1;
	assign samples.ready = room;
	assign in_fire = samples.valid && room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.peak_threshold <= '0;
			cfg_q.min_peak_distance <= opp_pkg::RESET_MIN_PEAK_DISTANCE;
		end else if (cfg.valid) begin
			if (cfg.index == opp_pkg::REG_PEAK_THRESHOLD) begin
				cfg_q.peak_threshold <= cfg.data[opp_pkg::THRESH_W-1:0];
			end else if (cfg.index == opp_pkg::REG_MIN_PEAK_DISTANCE) begin
				cfg_q.min_peak_distance <= cfg.data[opp_pkg::DIST_W-1:0];
			end
		end
	end

	opp_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (in_fire),
		.detect_value (samples.detect_value),
		.energy_value (samples.energy_value),
		.stream_end   (samples.stream_end),
		.cfg          (cfg_q),
		.push         (push)
	);

	opp_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (onsets.ready),
		.head      (head),
		.not_empty (onsets.valid),
		.room      (room)
	);

	assign onsets.onset_position = head.onset_position;
	assign onsets.onset_weight = head.onset_weight;
	assign onsets.no_onset = head.no_onset;
	assign onsets.list_end = head.list_end;

endmodule

/* sv/opp_checker.sv */
// port-level checks of the onset peak picker and their binding
`include "onset_peak_picker_defines.svh"

module opp_checker (
	input logic       clk,
	input logic       arst_n,
	opp_out_if.source onsets
);

	// an empty-stream marker is always the closing result and carries no peak
	`OPP_ASSERT_NOW(a_none_is_last, onsets.valid && onsets.no_onset, onsets.list_end, "no_onset without list_end")
	`OPP_ASSERT_NOW(a_none_is_zero, onsets.valid && onsets.no_onset, (onsets.onset_position == '0) && (onsets.onset_weight == '0), "no_onset with nonzero fields")
	`OPP_ASSERT_NEXT(a_hold_valid, onsets.valid && !onsets.ready, onsets.valid, "result dropped while stalled")
	`OPP_ASSERT_NEXT(a_hold_data, onsets.valid && !onsets.ready, $stable(onsets.onset_position) && $stable(onsets.onset_weight) && $stable(onsets.list_end), "result changed while stalled")

endmodule

bind onset_peak_picker opp_checker u_opp_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.onsets (onsets)
);

/* test/testbench.sv */
// testbench of the onset peak picker: directed table, random bands, back-pressure
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import opp_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int DRAIN_PAUSE = 4;
	localparam int PHASE_ITEMS = 75;
	localparam int PHASE_COUNT = 10;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic signed [DETECT_W-1:0] detect;
		logic        [ENERGY_W-1:0] energy;
		logic                       last;
		logic                       typed;
		opp_result_t                want;
	} band_row_t;

	localparam opp_result_t NO_ONSET_END = '{onset_position: '0, onset_weight: '0,
		no_onset: 1'b1, list_end: 1'b1};
	localparam opp_result_t UNTYPED = '0;
	localparam opp_result_t FIRST_PEAK_END = '{onset_position: 16'd1, onset_weight: 16'hFFFF,
		no_onset: 1'b0, list_end: 1'b1};

	localparam band_row_t DIRECTED_ROWS [26] = '{
		// one-sample band
		'{16'sd0, 16'd0, 1'b1, 1'b1, NO_ONSET_END},
		// four samples judge nothing
		'{16'sh7FFF, 16'hFFFF, 1'b0, 1'b0, UNTYPED},
		'{16'sh8000, 16'd0, 1'b0, 1'b0, UNTYPED},
		'{16'sh7FFF, 16'hFFFF, 1'b0, 1'b0, UNTYPED},
		'{16'sd0, 16'd0, 1'b1, 1'b1, NO_ONSET_END},
		// full-scale peak at position 1 with the largest rise
		'{16'sd0, 16'd0, 1'b0, 1'b0, UNTYPED},
		'{16'sh7FFF, 16'd0, 1'b0, 1'b0, UNTYPED},
		'{16'sd0, 16'hFFFF, 1'b0, 1'b0, UNTYPED},
		'{16'sh8000, 16'd0, 1'b0, 1'b0, UNTYPED},
		'{16'sd0, 16'd0, 1'b0, 1'b0, UNTYPED},
		'{16'sd0, 16'd0, 1'b0, 1'b0, UNTYPED},
		'{16'sd0, 16'd0, 1'b1, 1'b1, FIRST_PEAK_END},
		// region whose own detection values never go positive
		'{16'sd0, 16'd0, 1'b0, 1'b0, UNTYPED},
		'{16'sd0, 16'd0, 1'b0, 1'b0, UNTYPED},
		'{16'sd0, 16'd0, 1'b0, 1'b0, UNTYPED},
		'{16'sd1, 16'd0, 1'b0, 1'b0, UNTYPED},
		'{16'sd0, 16'd0, 1'b1, 1'b1, NO_ONSET_END},
		// two close peaks merge, the heavier one wins
		'{16'sd0, 16'd0, 1'b0, 1'b0, UNTYPED},
		'{16'sd1000, 16'd10, 1'b0, 1'b0, UNTYPED},
		'{16'sd0, 16'd50, 1'b0, 1'b0, UNTYPED},
		'{16'sd0, 16'd20, 1'b0, 1'b0, UNTYPED},
		'{16'sd0, 16'd0, 1'b0, 1'b0, UNTYPED},
		'{16'sd2000, 16'd0, 1'b0, 1'b0, UNTYPED},
		'{16'sd0, 16'd300, 1'b0, 1'b0, UNTYPED},
		'{16'sd0, 16'd0, 1'b0, 1'b0, UNTYPED},
		'{16'sd0, 16'd0, 1'b1, 1'b0, UNTYPED}
	};

	logic clk;
	logic arst_n;

	opp_in_if  samples_ch ();
	opp_out_if onsets_ch ();
	opp_cfg_if cfg_ch ();

	onset_peak_picker dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples_ch),
		.onsets(onsets_ch),
		.cfg(cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// band state of the predictor
	int                  win_detect [3];
	logic [ENERGY_W-1:0] win_energy [4];
	int unsigned         band_taken;
	bit                  region_open;
	int                  region_peak;
	logic [POS_W-1:0]    region_peak_pos;
	logic [WEIGHT_W-1:0] region_rise;
	bit                  cluster_open;
	logic [POS_W-1:0]    cluster_best_pos;
	logic [WEIGHT_W-1:0] cluster_best_weight;
	logic [POS_W-1:0]    cluster_tail_pos;
	logic [THRESH_W-1:0] cur_threshold;
	logic [DIST_W-1:0]   cur_distance;

	opp_result_t step_onsets [$];
	opp_result_t expected_onsets [$];

	int mismatches = 0;
	int cycle_count = 0;
	bit source_idling = 1'b1;
	bit sink_idling = 1'b1;
	int sink_hold = 0;

	function automatic void clear_band();
		for (int k = 0; k < 3; k++)
			win_detect[k] = 0;
		for (int k = 0; k < 4; k++)
			win_energy[k] = '0;
		band_taken = 0;
		region_open = 1'b0;
		region_peak = 0;
		region_peak_pos = '0;
		region_rise = '0;
		cluster_open = 1'b0;
		cluster_best_pos = '0;
		cluster_best_weight = '0;
		cluster_tail_pos = '0;
	endfunction

	function automatic opp_result_t onset_result(input logic [POS_W-1:0] pos,
			input logic [WEIGHT_W-1:0] weight, input logic none, input logic last);
		opp_result_t r;
		r.onset_position = pos;
		r.onset_weight = weight;
		r.no_onset = none;
		r.list_end = last;
		return r;
	endfunction

	function automatic void merge_candidate(input logic [POS_W-1:0] pos,
			input logic [WEIGHT_W-1:0] weight);
		int unsigned gap;
		gap = pos - cluster_tail_pos;
		if (cluster_open && gap < cur_distance) begin
			if (weight > cluster_best_weight) begin
				cluster_best_pos = pos;
				cluster_best_weight = weight;
			end
			cluster_tail_pos = pos;
		end else begin
			if (cluster_open)
				step_onsets.insert(step_onsets.size(), onset_result(cluster_best_pos,
					cluster_best_weight, 1'b0, 1'b0));
			cluster_open = 1'b1;
			cluster_best_pos = pos;
			cluster_best_weight = weight;
			cluster_tail_pos = pos;
		end
	endfunction

	function automatic void close_region();
		region_open = 1'b0;
		if (region_peak > int'(cur_threshold))
			merge_candidate(region_peak_pos, region_rise);
	endfunction

	function automatic void predict_onsets(input logic signed [DETECT_W-1:0] d,
			input logic [ENERGY_W-1:0] e, input logic last);
		int unsigned p;
		logic [POS_W-1:0] ps;
		int rise;
		if (band_taken < MAX_SAMPLES) begin
			if (band_taken >= FIRST_JUDGE_COUNT) begin
				p = band_taken - JUDGE_LAG;
				ps = (p > 65535) ? POS_MAX : p[POS_W-1:0];
				if (win_detect[0] > 0 || win_detect[1] > 0 || win_detect[2] > 0) begin
					if (!region_open) begin
						region_open = 1'b1;
						region_peak = 0;
						region_peak_pos = '0;
						region_rise = '0;
					end
					if (win_detect[0] > region_peak) begin
						region_peak = win_detect[0];
						region_peak_pos = ps;
					end
					// rise across the judged position: e[i+1] - e[i-1]
					rise = int'(win_energy[2]) - int'(win_energy[0]);
					if (rise > int'(region_rise))
						region_rise = rise[WEIGHT_W-1:0];
				end else if (region_open) begin
					close_region();
				end
			end
			win_detect[0] = win_detect[1];
			win_detect[1] = win_detect[2];
			win_detect[2] = int'(d);
			win_energy[0] = win_energy[1];
			win_energy[1] = win_energy[2];
			win_energy[2] = win_energy[3];
			win_energy[3] = e;
			band_taken++;
		end
		if (last) begin
			if (region_open)
				close_region();
			if (cluster_open)
				step_onsets.insert(step_onsets.size(), onset_result(cluster_best_pos,
					cluster_best_weight, 1'b0, 1'b1));
			else
				step_onsets.insert(step_onsets.size(), NO_ONSET_END);
			clear_band();
		end
	endfunction

	function automatic void apply_register(input logic [CFG_INDEX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		case (index)
			REG_PEAK_THRESHOLD: cur_threshold = data[THRESH_W-1:0];
			REG_MIN_PEAK_DISTANCE: cur_distance = data;
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] wanted);
		$display("%0t ns: %s got %h expected %h", $realtime, what, got, wanted);
		mismatches++;
	endtask

	always @(posedge clk) begin : onset_check
		opp_result_t want;
		if (arst_n && onsets_ch.valid === 1'b1 && onsets_ch.ready === 1'b1) begin
			if (expected_onsets.size() == 0) begin
				report_mismatch("unexpected result, position", onsets_ch.onset_position, '0);
			end else begin
				want = expected_onsets.pop_front();
				if (onsets_ch.onset_position !== want.onset_position)
					report_mismatch("onset_position", onsets_ch.onset_position,
						want.onset_position);
				if (onsets_ch.onset_weight !== want.onset_weight)
					report_mismatch("onset_weight", onsets_ch.onset_weight, want.onset_weight);
				if (onsets_ch.no_onset !== want.no_onset)
					report_mismatch("no_onset", 16'(onsets_ch.no_onset), 16'(want.no_onset));
				if (onsets_ch.list_end !== want.list_end)
					report_mismatch("list_end", 16'(onsets_ch.list_end), 16'(want.list_end));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("onset_peak_picker verification failed");
			$finish;
		end
	end

	// result side: random stalls, plus one long hold when asked
	initial begin : onset_sink
		int stall;
		onsets_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			stall = 0;
			if (sink_hold > 0) begin
				stall = sink_hold;
				sink_hold = 0;
			end else if (sink_idling && $urandom_range(0, 9) == 0) begin
				stall = $urandom_range(1, 19);
			end
			if (stall > 0) begin
				onsets_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			onsets_ch.ready <= 1'b1;
		end
	end

	task automatic send_sample(input logic signed [DETECT_W-1:0] d,
			input logic [ENERGY_W-1:0] e, input logic last, input logic typed,
			input opp_result_t want);
		samples_ch.valid <= 1'b1;
		samples_ch.detect_value <= d;
		samples_ch.energy_value <= e;
		samples_ch.stream_end <= last;
		do @(posedge clk); while (samples_ch.ready !== 1'b1);
		step_onsets.delete();
		predict_onsets(d, e, last);
		if (typed)
			expected_onsets.insert(expected_onsets.size(), want);
		else
			foreach (step_onsets[k])
				expected_onsets.insert(expected_onsets.size(), step_onsets[k]);
		if (source_idling && $urandom_range(0, 5) == 0) begin
			samples_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	// baseline of small negatives with positive pulses over a drifting energy; a noisy band uses random values
	task automatic send_band(input int len, input int pulse_pct, input bit noisy);
		int level;
		logic signed [DETECT_W-1:0] d;
		level = $urandom_range(0, 8000);
		for (int k = 0; k < len; k++) begin
			if (noisy)
				d = 16'($urandom);
			else if ($urandom_range(1, 100) <= pulse_pct)
				d = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 32767))
					: 16'($urandom_range(1, 4095));
			else
				d = 16'(-int'($urandom_range(0, 1500)));
			if (noisy || $urandom_range(0, 19) == 0)
				level = $urandom_range(0, 65535);
			else
				level = level + int'($urandom_range(0, 2400)) - 1200;
			if (level < 0)
				level = 0;
			else if (level > 65535)
				level = 65535;
			send_sample(d, 16'(level), k == len - 1, 1'b0, UNTYPED);
		end
	endtask

	task automatic drain_onsets();
		samples_ch.valid <= 1'b0;
		while (expected_onsets.size() != 0) @(posedge clk);
		repeat (DRAIN_PAUSE) @(posedge clk);
	endtask

	task automatic load_settings(input logic [CFG_DATA_W-1:0] threshold,
			input logic [CFG_DATA_W-1:0] distance);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= REG_PEAK_THRESHOLD;
		cfg_ch.data <= threshold;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		apply_register(REG_PEAK_THRESHOLD, threshold);
		cfg_ch.index <= REG_MIN_PEAK_DISTANCE;
		cfg_ch.data <= distance;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		apply_register(REG_MIN_PEAK_DISTANCE, distance);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin : stimulus
		int fed;
		int len;
		logic [CFG_DATA_W-1:0] threshold;
		logic [CFG_DATA_W-1:0] distance;
		arst_n <= 1'b0;
		samples_ch.valid <= 1'b0;
		samples_ch.detect_value <= '0;
		samples_ch.energy_value <= '0;
		samples_ch.stream_end <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_PEAK_THRESHOLD;
		cfg_ch.data <= '0;
		clear_band();
		cur_threshold = '0;
		cur_distance = RESET_MIN_PEAK_DISTANCE;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < $size(DIRECTED_ROWS); r++)
			send_sample(DIRECTED_ROWS[r].detect, DIRECTED_ROWS[r].energy,
				DIRECTED_ROWS[r].last, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);

		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			if (ph == PHASE_COUNT - 1) begin
				source_idling = 1'b0;
				drain_onsets();
				sink_idling = 1'b0;
			end
			drain_onsets();
			case (ph)
				0: begin
					threshold = '0;
					distance = '0;
				end
				1: begin
					threshold = '1;
					distance = 16'd1;
				end
				2: begin
					threshold = 16'($urandom_range(0, 2000));
					distance = '1;
				end
				default: begin
					threshold = ($urandom_range(0, 3) == 0) ? 16'($urandom)
						: 16'($urandom_range(0, 3000));
					distance = ($urandom_range(0, 3) == 0) ? 16'($urandom)
						: 16'($urandom_range(0, 30));
				end
			endcase
			load_settings(threshold, distance);
			// hold the result side while bands keep coming
			if (ph == 0)
				sink_hold = HOLD_CYCLES;
			fed = 0;
			while (fed < PHASE_ITEMS) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 40);
				send_band(len, $urandom_range(5, 50), $urandom_range(0, 19) == 0);
				fed += len;
			end
		end

		drain_onsets();
		if (mismatches == 0)
			$display("onset_peak_picker verification clean");
		else
			$display("onset_peak_picker verification failed");
		$finish;
	end

endmodule

/* files.f */
+incdir+sv
sv/opp_pkg.sv
sv/opp_if.sv
sv/opp_core.sv
sv/opp_out_queue.sv
sv/onset_peak_picker.sv
sv/opp_checker.sv
test/testbench.sv
